// File: rtl/core/pcta_pkg.sv
// Package for the preset countdown timer with alert.
// Holds the configuration and pipeline types, reset values and display constants.
// No dependencies; every other file of the block but pcta_if imports it.
package pcta_pkg;

  typedef enum logic [1:0] {
    CFG_STEP_MINUTES  = 2'd0,
    CFG_MIN_MINUTES   = 2'd1,
    CFG_MAX_MINUTES   = 2'd2,
    CFG_ALERT_SECONDS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0] step_minutes;
    logic [7:0] min_minutes;
    logic [7:0] max_minutes;
    logic [7:0] alert_seconds;
  } cfg_t;

  // Stage register between the state update and the display formatter.
  typedef struct packed {
    logic [13:0] shown;
    logic        blink_phase;
    logic        alerting;
    logic        is_running;
  } disp_t;

  localparam logic [5:0] STEP_RESET   = 6'd5;
  localparam logic [7:0] MIN_RESET    = 8'd5;
  localparam logic [7:0] MAX_RESET    = 8'd255;
  localparam logic [7:0] ALERT_RESET  = 8'd5;
  localparam logic [7:0] PRESET_RESET = 8'd30;

  localparam logic [2:0] BRIGHT_IDLE  = 3'd1;
  localparam logic [2:0] BRIGHT_RUN   = 3'd4;
  localparam logic [2:0] BRIGHT_FLASH = 3'd7;
  localparam logic [2:0] BRIGHT_DIM   = 3'd1;

  localparam logic [7:0] MIN_PER_HOUR = 8'd60;

  // Ceiling reciprocal of 15 scaled by 2^16; exact for dividends below 4681.
  localparam logic [12:0] DIV15_RECIP = 13'd4370;

  function automatic logic [13:0] times60(input logic [7:0] m);
    logic [13:0] w;
    w = {6'd0, m};
    return (w << 6) - (w << 2);
  endfunction

endpackage

// File: rtl/core/pcta_if.sv
// Handshake channel interfaces of the preset countdown timer with alert.
// Input updates, result items and configuration writes; no dependencies.
interface pcta_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_seconds;
  logic        blink_phase;
  logic        inc_active;
  logic        dec_active;
  logic        start_edge;

  modport source (output valid, now_seconds, blink_phase, inc_active, dec_active,
                  start_edge, input ready);
  modport sink   (input valid, now_seconds, blink_phase, inc_active, dec_active,
                  start_edge, output ready);
endinterface

interface pcta_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] high_pair;
  logic [5:0] low_pair;
  logic [2:0] brightness;
  logic       alerting;
  logic       is_running;

  modport source (output valid, high_pair, low_pair, brightness, alerting, is_running,
                  input ready);
  modport sink   (input valid, high_pair, low_pair, brightness, alerting, is_running,
                  output ready);
endinterface

interface pcta_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/preset_countdown_timer_with_alert.sv
// Top level of the preset countdown timer with alert.
// Ties the configuration registers, the state update and the display formatter.
// Depends on pcta_pkg, pcta_if, pcta_cfg, pcta_ctrl and pcta_fmt.
//
// The in_i channel carries one update beat per tick: seconds count, blink phase
// and the three key flags. Every update beat yields exactly one beat on out_o
// with the two digit pairs, brightness and the alert and run flags. The cfg_i
// channel writes step, lower limit, upper limit and alert length by index; it
// is always ready and should be used only while no update is in flight.
//
// A result passes the stage register after the state update and then the output
// register after the formatter, and either register can hold it while out_o
// stalls. The block takes one update per cycle for as long as out_o keeps up.
//
// Reset loads a 30 minute preset with the timer stopped, the alert clear and
// the configuration at its reset values. When out_o stalls, the output beat is
// held, the stage register fills, and in_i ready drops after two beats.
module preset_countdown_timer_with_alert (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcta_in_if.sink    in_i,
  pcta_out_if.source out_o,
  pcta_cfg_if.sink   cfg_i
);
  import pcta_pkg::*;

  cfg_t  cfg;
  disp_t disp;
  logic  disp_valid;
  logic  fmt_ready;

  pcta_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  pcta_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .cfg_i   (cfg),
    .adv_i   (fmt_ready),
    .valid_o (disp_valid),
    .disp_o  (disp)
  );

  pcta_fmt u_fmt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (disp_valid),
    .disp_i  (disp),
    .ready_o (fmt_ready),
    .out_o   (out_o)
  );

endmodule

// File: rtl/core/pcta_cfg.sv
// Configuration register file of the preset countdown timer with alert.
// Depends on pcta_pkg and the pcta_cfg_if channel.
module pcta_cfg (
  input  logic           clk_i,
  input  logic           rst_ni,
  pcta_cfg_if.sink       cfg_i,
  output pcta_pkg::cfg_t cfg_o
);
  import pcta_pkg::*;

  cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_STEP_MINUTES:  cfg_d.step_minutes  = cfg_i.data[5:0];
        CFG_MIN_MINUTES:   cfg_d.min_minutes   = cfg_i.data;
        CFG_MAX_MINUTES:   cfg_d.max_minutes   = cfg_i.data;
        CFG_ALERT_SECONDS: cfg_d.alert_seconds = cfg_i.data;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_minutes  <= STEP_RESET;
      cfg_q.min_minutes   <= MIN_RESET;
      cfg_q.max_minutes   <= MAX_RESET;
      cfg_q.alert_seconds <= ALERT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/pcta_ctrl.sv
// Timer state update of the preset countdown timer with alert.
// Steps the preset, runs the countdown and alert, and loads the stage register.
// Depends on pcta_pkg and the pcta_in_if channel.
module pcta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  pcta_in_if.sink         in_i,
  input  pcta_pkg::cfg_t  cfg_i,
  input  logic            adv_i,
  output logic            valid_o,
  output pcta_pkg::disp_t disp_o
);
  import pcta_pkg::*;

  logic [7:0]  preset_d, preset_q;
  logic        run_d, run_q;
  logic [31:0] start_d, start_q;
  logic        alert_d, alert_q;
  logic        v_d, v_q;
  disp_t       st_d, st_q;

  logic        acc;
  logic [8:0]  up_sum;
  logic [7:0]  preset_inc;
  logic [9:0]  down_diff;
  logic [13:0] shown;
  logic [31:0] elapsed;
  logic [14:0] stop_at;
  logic        run_s, alert_s;
  logic [31:0] start_s;

  assign in_i.ready = !v_q || adv_i;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    preset_inc = preset_q;
    preset_d   = preset_q;
    up_sum     = {1'b0, preset_q} + {3'd0, cfg_i.step_minutes};
    if (!run_q && in_i.inc_active) begin
      preset_inc = (up_sum < {1'b0, cfg_i.max_minutes}) ? up_sum[7:0] : cfg_i.max_minutes;
    end
    down_diff = {2'd0, preset_inc} - {4'd0, cfg_i.step_minutes};
    preset_d  = preset_inc;
    if (!run_q && in_i.dec_active) begin
      preset_d = ($signed(down_diff) > $signed({2'd0, cfg_i.min_minutes})) ?
                 down_diff[7:0] : cfg_i.min_minutes;
    end

    run_s   = in_i.start_edge ? !run_q : run_q;
    start_s = in_i.start_edge ? in_i.now_seconds : start_q;
    alert_s = in_i.start_edge ? 1'b0 : alert_q;

    shown   = times60(preset_d);
    elapsed = in_i.now_seconds - start_s;
    stop_at = {1'b0, shown} + {7'd0, cfg_i.alert_seconds};

    run_d   = run_s;
    start_d = start_s;
    alert_d = alert_s;
    st_d.shown = shown;
    if (run_s) begin
      if ((elapsed >= {18'd0, shown}) || alert_s) begin
        alert_d = 1'b1;
        if (elapsed >= {17'd0, stop_at}) begin
          alert_d = 1'b0;
          run_d   = 1'b0;
          start_d = in_i.now_seconds;
        end
        st_d.shown = '0;
      end else begin
        st_d.shown = shown - elapsed[13:0];
      end
    end
    st_d.blink_phase = in_i.blink_phase;
    st_d.alerting    = alert_d;
    st_d.is_running  = run_d;

    v_d = acc ? 1'b1 : (adv_i ? 1'b0 : v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q <= PRESET_RESET;
      run_q    <= 1'b0;
      start_q  <= '0;
      alert_q  <= 1'b0;
      v_q      <= 1'b0;
    end else begin
      v_q <= v_d;
      if (acc) begin
        preset_q <= preset_d;
        run_q    <= run_d;
        start_q  <= start_d;
        alert_q  <= alert_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      st_q <= st_d;
    end
  end

  assign valid_o = v_q;
  assign disp_o  = st_q;

  a_preset_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> $stable(preset_q))
    else $error("preset changed without an accepted update");

  a_alert_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alert_q |-> run_q)
    else $error("alert set while the timer is stopped");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !adv_i |=> v_q && $stable(st_q))
    else $error("stage register lost or changed a stalled beat");

  // The beat on which the alert ends and the timer stops shows zero.
  a_idle_shows_preset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !st_q.is_running |-> (st_q.shown == times60(preset_q)) || (st_q.shown == '0))
    else $error("idle time does not match the preset");

endmodule

// File: rtl/core/pcta_fmt.sv
// Display formatter of the preset countdown timer with alert.
// Splits the shown seconds into digit pairs, picks brightness, holds the output register.
// Depends on pcta_pkg and the pcta_out_if channel.
module pcta_fmt (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  pcta_pkg::disp_t disp_i,
  output logic            ready_o,
  pcta_out_if.source      out_o
);
  import pcta_pkg::*;

  logic        v_d, v_q;
  logic        ld;
  logic [24:0] prod;
  logic [7:0]  minutes;
  logic [13:0] secs;
  logic [7:0]  hour_base;
  logic [2:0]  hours;
  logic [7:0]  mins_in_hour;
  logic [5:0]  high_d, high_q;
  logic [5:0]  low_d, low_q;
  logic [2:0]  bright_d, bright_q;
  logic        alert_q, run_q;

  assign ready_o = !v_q || out_o.ready;
  assign ld      = valid_i && ready_o;

  always_comb begin
    prod    = {1'b0, disp_i.shown[13:2]} * {12'd0, DIV15_RECIP};
    minutes = prod[23:16];
    secs    = disp_i.shown - times60(minutes);

    priority if (minutes >= 8'd240) begin
      hours = 3'd4;  hour_base = 8'd240;
    end else if (minutes >= 8'd180) begin
      hours = 3'd3;  hour_base = 8'd180;
    end else if (minutes >= 8'd120) begin
      hours = 3'd2;  hour_base = 8'd120;
    end else if (minutes >= MIN_PER_HOUR) begin
      hours = 3'd1;  hour_base = MIN_PER_HOUR;
    end else begin
      hours = 3'd0;  hour_base = 8'd0;
    end
    mins_in_hour = minutes - hour_base;

    if (minutes >= MIN_PER_HOUR) begin
      high_d = {3'd0, hours};
      low_d  = mins_in_hour[5:0];
    end else begin
      high_d = minutes[5:0];
      low_d  = secs[5:0];
    end

    if (disp_i.alerting) begin
      bright_d = disp_i.blink_phase ? BRIGHT_FLASH : BRIGHT_DIM;
    end else begin
      bright_d = disp_i.is_running ? BRIGHT_RUN : BRIGHT_IDLE;
    end

    v_d = ld ? 1'b1 : (out_o.ready ? 1'b0 : v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      high_q   <= high_d;
      low_q    <= low_d;
      bright_q <= bright_d;
      alert_q  <= disp_i.alerting;
      run_q    <= disp_i.is_running;
    end
  end

  assign out_o.valid      = v_q;
  assign out_o.high_pair  = high_q;
  assign out_o.low_pair   = low_q;
  assign out_o.brightness = bright_q;
  assign out_o.alerting   = alert_q;
  assign out_o.is_running = run_q;

endmodule
